/* rtl/core/dchs_pkg.sv */
// Shared constants, register indexes and controller/datapath interface types.
`default_nettype none

package dchs_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int DIST_BITS    = 16;
  localparam int FRAC_BITS    = 16;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ACT_W        = FRAC_BITS + 1;
  localparam int TIME_W       = 32;
  localparam int PERIOD_W     = 16;
  localparam int FLOOR_W      = 16;
  localparam int MASK_W       = 8;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int ONTIME_W     = 16;
  localparam int OUT_CH_W     = 3;

  localparam logic [ACT_W-1:0] ACT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK     = 3'd4;

  localparam logic [DIST_BITS-1:0] RST_MIN_DIST = '0;
  localparam logic [DIST_BITS-1:0] RST_MAX_DIST = '1;
  localparam logic [PERIOD_W-1:0]  RST_PERIOD   = 16'd200;
  localparam logic [FLOOR_W-1:0]   RST_FLOOR    = '0;
  localparam logic [MASK_W-1:0]    RST_MASK     = 8'd241;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;

  typedef logic [DIST_BITS-1:0] dist_t;

  typedef struct packed {
    logic            load;
    logic            chan_begin;
    logic            div_start;
    logic            square;
    logic            mul;
    logic            finish;
    logic            emit;
    logic            tick_done;
    logic [CH_W-1:0] ch;
  } dchs_cmd_t;

  typedef struct packed {
    logic chan_en;
    logic need_calc;
    logic div_busy;
    logic out_free;
  } dchs_status_t;

endpackage

`default_nettype wire

/* rtl/core/dchs_div.sv */
// Bit-serial restoring divider that forms the normalized distance ratio.
`default_nettype none

module dchs_div import dchs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIST_BITS-1:0] gap,
  input  wire logic [DIST_BITS-1:0] span,
  output logic                      busy,
  output logic [FRAC_BITS-1:0]      quotient
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [DIST_BITS:0]   rem;
  logic [DIST_BITS-1:0] span_r;
  logic [CNT_W-1:0]     cnt;
  logic [DIST_BITS:0]   trial;
  logic                 fits;

  assign trial = {rem[DIST_BITS-1:0], 1'b0};
  assign fits  = trial >= {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(FRAC_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, gap};
      span_r   <= span;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? (trial - {1'b0, span_r}) : trial;
      quotient <= {quotient[FRAC_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dchs_datapath.sv */
// Configuration, belt and channel state, activation arithmetic and result register.
`default_nettype none

module dchs_datapath import dchs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic [TIME_W-1:0]    now_ms,
  input  wire dist_t                dist_in [MAX_CHANNELS],
  input  wire dchs_cmd_t            cmd,
  output dchs_status_t              status,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [OUT_CH_W-1:0]       channel,
  output logic                      motor_on,
  output logic [ACT_W-1:0]          intensity,
  output logic                      last
);

  logic [DIST_BITS-1:0] min_dist;
  logic [DIST_BITS-1:0] max_dist;
  logic [PERIOD_W-1:0]  period;
  logic [FLOOR_W-1:0]   floor_q;
  logic [MASK_W-1:0]    en_mask;

  logic [TIME_W-1:0]       cycle_start_time;
  logic [TIME_W-1:0]       next_cycle_time;
  logic                    belt_active;
  logic [NUM_CHANNELS-1:0] channel_active;
  logic [ONTIME_W-1:0]     on_time_ms [NUM_CHANNELS];

  logic [TIME_W-1:0]    now_r;
  dist_t                dist_r [NUM_CHANNELS];
  logic [1:0]           mode_r;
  logic                 any_on;

  logic [ACT_W-1:0]             act_r;
  logic [ACT_W+PERIOD_W-1:0]    ontime_prod;
  logic [2*ACT_W-1:0]           drop_prod;
  logic [ACT_W-1:0]             inten_r;

  dist_t                 d_cur;
  logic                  ge_hi;
  logic                  le_lo;
  logic [DIST_BITS-1:0]  gap;
  logic [DIST_BITS-1:0]  span;
  logic                  div_busy;
  logic [FRAC_BITS-1:0]  ratio;
  logic [2*FRAC_BITS-1:0] ratio_sq;
  logic [TIME_W-1:0]     end_time;
  logic                  expired;
  logic                  cur_active;
  logic                  cur_en;
  logic [ACT_W-1:0]      floor_sat;
  logic [ACT_W:0]        drop;
  logic [ACT_W:0]        inten_full;
  logic                  is_last;
  logic [NUM_CHANNELS-1:0] en_vec;
  logic                  out_free;

  assign en_vec     = en_mask[NUM_CHANNELS-1:0];
  assign d_cur      = dist_r[cmd.ch];
  assign ge_hi      = d_cur >= max_dist;
  assign le_lo      = d_cur <= min_dist;
  assign gap        = max_dist - d_cur;
  assign span       = max_dist - min_dist;
  assign ratio_sq   = (2*FRAC_BITS)'(ratio) * (2*FRAC_BITS)'(ratio);
  assign cur_active = channel_active[cmd.ch];
  assign cur_en     = en_vec[cmd.ch];
  assign end_time   = cycle_start_time + TIME_W'(on_time_ms[cmd.ch]);
  assign expired    = now_r > end_time;
  assign floor_sat  = ({1'b0, floor_q} > ACT_ONE) ? ACT_ONE : ACT_W'(floor_q);
  assign drop       = drop_prod[FRAC_BITS +: ACT_W+1];
  assign inten_full = {1'b0, ACT_ONE} - drop;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    is_last = 1'b1;
    for (int j = 0; j < NUM_CHANNELS; j++) begin
      if ((CH_W'(j) > cmd.ch) && en_vec[j]) begin
        is_last = 1'b0;
      end
    end
  end

  always_comb begin
    status.chan_en   = cur_en;
    status.need_calc = cur_en && ((mode_r == MODE_START) ||
                       ((mode_r == MODE_RUN) && cur_active && !expired));
    status.div_busy  = div_busy;
    status.out_free  = out_free;
  end

  dchs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .gap      (gap),
    .span     (span),
    .busy     (div_busy),
    .quotient (ratio)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist <= RST_MIN_DIST;
      max_dist <= RST_MAX_DIST;
      period   <= RST_PERIOD;
      floor_q  <= RST_FLOOR;
      en_mask  <= RST_MASK;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_DIST: min_dist <= cfg_data[DIST_BITS-1:0];
        REG_MAX_DIST: max_dist <= cfg_data[DIST_BITS-1:0];
        REG_PERIOD:   period   <= cfg_data[PERIOD_W-1:0];
        REG_FLOOR:    floor_q  <= cfg_data[FLOOR_W-1:0];
        REG_MASK:     en_mask  <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_start_time <= '0;
      next_cycle_time  <= '0;
      belt_active      <= 1'b0;
      channel_active   <= '0;
    end else begin
      if (cmd.chan_begin && (mode_r == MODE_RUN) && cur_active && expired) begin
        channel_active[cmd.ch] <= 1'b0;
      end
      if (cmd.finish && (mode_r == MODE_START)) begin
        channel_active[cmd.ch] <= 1'b1;
      end
      if (cmd.tick_done) begin
        if (mode_r == MODE_START) begin
          belt_active      <= 1'b1;
          cycle_start_time <= next_cycle_time;
          next_cycle_time  <= next_cycle_time + TIME_W'(period);
        end else if ((mode_r == MODE_RUN) && !any_on) begin
          belt_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= now_ms;
      any_on <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        dist_r[i] <= dist_in[i];
      end
      if (!belt_active && (now_ms >= next_cycle_time)) begin
        mode_r <= MODE_START;
      end else if (belt_active) begin
        mode_r <= MODE_RUN;
      end else begin
        mode_r <= MODE_IDLE;
      end
    end
    if (cmd.chan_begin) begin
      inten_r <= '0;
      if ((mode_r == MODE_RUN) && cur_active && !expired) begin
        any_on <= 1'b1;
      end
    end
    if (cmd.square) begin
      if (ge_hi) begin
        act_r <= '0;
      end else if (le_lo) begin
        act_r <= ACT_ONE;
      end else begin
        act_r <= {1'b0, ratio_sq[2*FRAC_BITS-1:FRAC_BITS]};
      end
    end
    if (cmd.mul) begin
      ontime_prod <= (ACT_W+PERIOD_W)'(act_r) * (ACT_W+PERIOD_W)'(period);
      drop_prod   <= (2*ACT_W)'(ACT_ONE - act_r) * (2*ACT_W)'(ACT_ONE - floor_sat);
    end
    if (cmd.finish) begin
      inten_r <= (act_r == '0) ? '0 : inten_full[ACT_W-1:0];
      if (mode_r == MODE_START) begin
        on_time_ms[cmd.ch] <= ontime_prod[FRAC_BITS +: ONTIME_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      channel   <= OUT_CH_W'(cmd.ch);
      motor_on  <= cur_active;
      intensity <= cur_active ? inten_r : '0;
      last      <= is_last;
    end
  end

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("A result beat was loaded while the previous one was still held.");

  a_belt_on_at_start: assert property (@(posedge clk) disable iff (rst)
    $rose(belt_active) |-> ($past(cmd.tick_done) && ($past(mode_r) == MODE_START)))
    else $error("The belt switched on outside the end of a cycle-start tick.");

  a_start_all_on: assert property (@(posedge clk) disable iff (rst)
    (cmd.tick_done && (mode_r == MODE_START)) |=>
      ((channel_active & $past(en_vec)) == $past(en_vec)))
    else $error("An enabled channel is off after a cycle-start tick.");

endmodule

`default_nettype wire

/* rtl/core/dchs_ctrl.sv */
// Controller state machine that sequences the channels of one tick.
`default_nettype none

module dchs_ctrl import dchs_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire dchs_status_t status,
  output dchs_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;
  localparam logic [2:0] S_NEXT = 3'd7;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [CH_W-1:0] ch;
  logic [CH_W-1:0] ch_next;
  logic            last_ch;

  assign item_stall = (state != S_IDLE);
  assign last_ch    = (ch == CH_W'(NUM_CHANNELS - 1));

  always_comb begin
    state_next     = state;
    ch_next        = ch;
    cmd            = '0;
    cmd.ch         = ch;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          ch_next    = '0;
          state_next = S_CHAN;
        end
      end
      S_CHAN: begin
        if (!status.chan_en) begin
          state_next = S_NEXT;
        end else begin
          cmd.chan_begin = 1'b1;
          if (status.need_calc) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (last_ch) begin
          cmd.tick_done = 1'b1;
          state_next    = S_IDLE;
        end else begin
          ch_next    = ch + 1'b1;
          state_next = S_CHAN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/duty_cycle_haptic_scheduler.sv */
// Top level of the duty-cycle haptic belt scheduler.
// Each accepted tick carries the time in milliseconds and one distance per motor
// channel, and yields one result beat per enabled channel in ascending order, with
// last set on the highest enabled one. Channels are worked one after another by a
// single bit-serial divider that produces one quotient bit per cycle: a channel
// whose activation is computed (every enabled channel at a cycle start, and every
// channel still on during a cycle) passes through the channel, divide, square,
// multiply, finish, emit and next states, any other enabled channel through the
// channel, emit and next states, and a disabled one through channel and next.
// The next tick is taken once every result of the current one has been loaded
// into the output register. Configuration writes take effect at once and are
// meant for times when no tick is in flight.
`default_nettype none

module duty_cycle_haptic_scheduler import dchs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire logic [TIME_W-1:0]    now_ms,
  input  wire logic [DIST_BITS-1:0] distance_0,
  input  wire logic [DIST_BITS-1:0] distance_1,
  input  wire logic [DIST_BITS-1:0] distance_2,
  input  wire logic [DIST_BITS-1:0] distance_3,
  input  wire logic [DIST_BITS-1:0] distance_4,
  input  wire logic [DIST_BITS-1:0] distance_5,
  input  wire logic [DIST_BITS-1:0] distance_6,
  input  wire logic [DIST_BITS-1:0] distance_7,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [OUT_CH_W-1:0]       channel,
  output logic                      motor_on,
  output logic [ACT_W-1:0]          intensity,
  output logic                      last
);

  dist_t        dist_in [MAX_CHANNELS];
  dchs_cmd_t    cmd;
  dchs_status_t status;

  assign dist_in[0] = distance_0;
  assign dist_in[1] = distance_1;
  assign dist_in[2] = distance_2;
  assign dist_in[3] = distance_3;
  assign dist_in[4] = distance_4;
  assign dist_in[5] = distance_5;
  assign dist_in[6] = distance_6;
  assign dist_in[7] = distance_7;

  dchs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  dchs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .now_ms       (now_ms),
    .dist_in      (dist_in),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .channel      (channel),
    .motor_on     (motor_on),
    .intensity    (intensity),
    .last         (last)
  );

endmodule

`default_nettype wire
